// File: hdl/aieu_pkg.sv
// Package of shared types, codes and helper functions for the ARM integer execute unit.
`timescale 1ns / 1ps
package aieu_pkg;

   localparam logic [2:0] KIND_STEP  = 3'd0;
   localparam logic [2:0] KIND_READ  = 3'd1;
   localparam logic [2:0] KIND_WRITE = 3'd2;
   localparam logic [2:0] KIND_SVC   = 3'd3;
   localparam logic [2:0] KIND_HALT  = 3'd4;

   localparam logic REG_FAULT_START = 1'b0;
   localparam logic REG_FAULT_END   = 1'b1;

   localparam logic [31:0] FAULT_START_RST = 32'h0FFF_F000;
   localparam logic [31:0] FAULT_END_RST   = 32'h1000_0000;
   localparam logic [31:0] BX_MASK         = 32'h0FFF_FFD0;
   localparam logic [31:0] BX_PATTERN      = 32'h012F_FF10;
   localparam logic [27:0] NOP_PATTERN     = 28'h1A0_0000;
   localparam logic [3:0]  SVC_PATTERN     = 4'hF;

   localparam logic [3:0] PC_INDEX = 4'd15;

   localparam logic [3:0] COND_EQ = 4'd0;
   localparam logic [3:0] COND_NE = 4'd1;
   localparam logic [3:0] COND_CS = 4'd2;
   localparam logic [3:0] COND_CC = 4'd3;
   localparam logic [3:0] COND_MI = 4'd4;
   localparam logic [3:0] COND_PL = 4'd5;
   localparam logic [3:0] COND_VS = 4'd6;
   localparam logic [3:0] COND_VC = 4'd7;
   localparam logic [3:0] COND_HI = 4'd8;
   localparam logic [3:0] COND_LS = 4'd9;
   localparam logic [3:0] COND_GE = 4'd10;
   localparam logic [3:0] COND_LT = 4'd11;
   localparam logic [3:0] COND_GT = 4'd12;
   localparam logic [3:0] COND_LE = 4'd13;
   localparam logic [3:0] COND_AL = 4'd14;

   localparam logic [3:0] OP_AND = 4'd0;
   localparam logic [3:0] OP_EOR = 4'd1;
   localparam logic [3:0] OP_SUB = 4'd2;
   localparam logic [3:0] OP_RSB = 4'd3;
   localparam logic [3:0] OP_ADD = 4'd4;
   localparam logic [3:0] OP_ADC = 4'd5;
   localparam logic [3:0] OP_SBC = 4'd6;
   localparam logic [3:0] OP_RSC = 4'd7;
   localparam logic [3:0] OP_TST = 4'd8;
   localparam logic [3:0] OP_TEQ = 4'd9;
   localparam logic [3:0] OP_CMP = 4'd10;
   localparam logic [3:0] OP_CMN = 4'd11;
   localparam logic [3:0] OP_ORR = 4'd12;
   localparam logic [3:0] OP_MOV = 4'd13;
   localparam logic [3:0] OP_BIC = 4'd14;
   localparam logic [3:0] OP_MVN = 4'd15;

   localparam logic [1:0] SHIFT_LSL = 2'd0;
   localparam logic [1:0] SHIFT_LSR = 2'd1;
   localparam logic [1:0] SHIFT_ASR = 2'd2;
   localparam logic [1:0] SHIFT_ROR = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_A,
      ST_RD_B,
      ST_EXEC,
      ST_STM,
      ST_WB
   } state_type;

   typedef struct packed {
      logic accept;
      logic rd_a;
      logic rd_b;
      logic exec;
      logic stm;
      logic wb;
   } cmd_type;

   typedef struct packed {
      logic to_stm;
      logic to_wb;
      logic stm_last;
      logic out_free;
   } sts_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] addr;
      logic [31:0] wdata;
      logic        byte_acc;
      logic [23:0] svc;
      logic        rwv;
      logic [3:0]  rwi;
      logic [31:0] rwval;
      logic        last;
   } rsp_type;

   function automatic logic [3:0] lowest_set(input logic [15:0] m);
      logic [3:0] r;
      r = PC_INDEX;
      for (int k = 15; k >= 0; k--) begin
         if (m[k]) r = 4'(k);
      end
      return r;
   endfunction

   function automatic logic [4:0] pop_count(input logic [15:0] m);
      logic [4:0] c;
      c = 5'd0;
      for (int k = 0; k < 16; k++) begin
         c = c + {4'd0, m[k]};
      end
      return c;
   endfunction

endpackage

// File: hdl/arm_integer_execute_unit.sv
// Top level of the ARM integer execute unit: configuration registers, sequencer and datapath.
//
// The request channel (req_*) carries either an instruction word fetched at the current pc
// (req_command 0) or the data answering the oldest outstanding read (req_command 1).
// Each request beat gives one or more result beats on rsp_*, the final one with rsp_last.
// Memory reads and writes leave as result beats of kind read or write; load data must come
// back as further request beats.
// An accepted beat reads its operands in RD_A and RD_B through the single register-file read
// port and executes in EXEC, which registers the first result of every beat but a store
// multiple; the next request is taken in the cycle after the final result is registered.
// A store multiple registers its writes in STM after EXEC, one write per cycle while the
// output register is free. Every store, and a load whose final word brings a base writeback,
// adds a closing beat from WB.
// A stalled result holds in the output register; a new request is still taken meanwhile,
// and its own result waits until the output register is free.
// The APB port at psel/penable sets the fault window (word 0 start, word 1 end, exclusive).
// Reset clears the registers, flags, pc and pending loads, and restores the default window.
`timescale 1ns / 1ps
module arm_integer_execute_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [31:0] req_instr_word,
   input  logic [31:0] req_load_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [31:0] rsp_mem_address,
   output logic [31:0] rsp_write_data,
   output logic        rsp_byte_access,
   output logic [31:0] rsp_next_pc,
   output logic [3:0]  rsp_nzcv,
   output logic [23:0] rsp_svc_number,
   output logic        rsp_reg_write_valid,
   output logic [3:0]  rsp_reg_write_index,
   output logic [31:0] rsp_reg_write_value,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [31:0] fault_start_ff, fault_end_ff;
   aieu_pkg::cmd_type cmd;
   aieu_pkg::sts_type sts;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fault_start_ff <= aieu_pkg::FAULT_START_RST;
         fault_end_ff <= aieu_pkg::FAULT_END_RST;
      end else if (psel && penable && pwrite && pready) begin
         if (paddr[2] == aieu_pkg::REG_FAULT_END) begin
            fault_end_ff <= pwdata;
         end else begin
            fault_start_ff <= pwdata;
         end
      end
   end

   assign prdata = (paddr[2] == aieu_pkg::REG_FAULT_START) ? fault_start_ff : fault_end_ff;

   aieu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   aieu_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .fault_start         (fault_start_ff),
      .fault_end           (fault_end_ff),
      .req_command         (req_command),
      .req_instr_word      (req_instr_word),
      .req_load_data       (req_load_data),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_mem_address     (rsp_mem_address),
      .rsp_write_data      (rsp_write_data),
      .rsp_byte_access     (rsp_byte_access),
      .rsp_next_pc         (rsp_next_pc),
      .rsp_nzcv            (rsp_nzcv),
      .rsp_svc_number      (rsp_svc_number),
      .rsp_reg_write_valid (rsp_reg_write_valid),
      .rsp_reg_write_index (rsp_reg_write_index),
      .rsp_reg_write_value (rsp_reg_write_value),
      .rsp_last            (rsp_last)
   );

endmodule

// File: hdl/aieu_ctrl.sv
// Sequencer of the ARM integer execute unit: steps each beat through read, execute and emit.
`timescale 1ns / 1ps
module aieu_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  aieu_pkg::sts_type sts,
   output aieu_pkg::cmd_type cmd
);

   aieu_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= aieu_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         aieu_pkg::ST_IDLE: begin
            if (req_valid) state_in = aieu_pkg::ST_RD_A;
         end
         aieu_pkg::ST_RD_A: state_in = aieu_pkg::ST_RD_B;
         aieu_pkg::ST_RD_B: state_in = aieu_pkg::ST_EXEC;
         aieu_pkg::ST_EXEC: begin
            if (sts.to_stm) begin
               state_in = aieu_pkg::ST_STM;
            end else if (sts.out_free) begin
               state_in = sts.to_wb ? aieu_pkg::ST_WB : aieu_pkg::ST_IDLE;
            end
         end
         aieu_pkg::ST_STM: begin
            if (sts.out_free && sts.stm_last) state_in = aieu_pkg::ST_WB;
         end
         aieu_pkg::ST_WB: begin
            if (sts.out_free) state_in = aieu_pkg::ST_IDLE;
         end
         default: state_in = aieu_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         aieu_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.accept = req_valid;
         end
         aieu_pkg::ST_RD_A: cmd.rd_a = 1'b1;
         aieu_pkg::ST_RD_B: cmd.rd_b = 1'b1;
         aieu_pkg::ST_EXEC: cmd.exec = sts.to_stm || sts.out_free;
         aieu_pkg::ST_STM:  cmd.stm = sts.out_free;
         aieu_pkg::ST_WB:   cmd.wb = sts.out_free;
         default: req_stall = 1'b1;
      endcase
   end

endmodule

// File: hdl/aieu_dpath.sv
// Datapath of the ARM integer execute unit: register file, flags, shifter, ALU and result register.
`timescale 1ns / 1ps
module aieu_dpath (
   input  logic              clock,
   input  logic              reset,
   input  aieu_pkg::cmd_type cmd,
   output aieu_pkg::sts_type sts,
   input  logic [31:0]       fault_start,
   input  logic [31:0]       fault_end,
   input  logic              req_command,
   input  logic [31:0]       req_instr_word,
   input  logic [31:0]       req_load_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_kind,
   output logic [31:0]       rsp_mem_address,
   output logic [31:0]       rsp_write_data,
   output logic              rsp_byte_access,
   output logic [31:0]       rsp_next_pc,
   output logic [3:0]        rsp_nzcv,
   output logic [23:0]       rsp_svc_number,
   output logic              rsp_reg_write_valid,
   output logic [3:0]        rsp_reg_write_index,
   output logic [31:0]       rsp_reg_write_value,
   output logic              rsp_last
);

   // Registers 0 to 14; the program counter is held on its own.
   logic [31:0] rf_ff [15];
   logic [31:0] pc_ff, pc_in;
   logic [3:0]  flags_ff, flags_in;
   logic [15:0] mask_ff, mask_in;
   logic [31:0] paddr_ff, paddr_in;
   logic        pbyte_ff, pbyte_in;
   logic        pwbv_ff, pwbv_in;
   logic [31:0] pwbval_ff, pwbval_in;
   logic [3:0]  pwbidx_ff, pwbidx_in;
   logic [15:0] lst_ff, lst_in;
   logic [31:0] saddr_ff;
   logic [31:0] saddr_in;

   logic        cmd_ff;
   logic [31:0] ins_ff, ld_ff, pc0_ff, a_ff, b_ff, m_ff;
   logic        sc_ff;

   logic        rf_we;
   logic [3:0]  rf_wi;
   logic [31:0] rf_wv;

   logic              rsp_valid_ff;
   aieu_pkg::rsp_type rsp_ff, res;
   logic [31:0]       next_pc_ff;
   logic [3:0]        nzcv_ff;
   logic              emit;

   // Single read port of the register file.
   logic [3:0]  ridx;
   logic [31:0] rval;

   always_comb begin
      if (cmd.rd_a) begin
         ridx = ins_ff[19:16];
      end else if (cmd.rd_b) begin
         ridx = (ins_ff[27:26] == 2'b01) ? ins_ff[15:12] : ins_ff[3:0];
      end else begin
         ridx = aieu_pkg::lowest_set(lst_ff);
      end
      rval = (ridx == aieu_pkg::PC_INDEX) ? pc0_ff + 32'd8 : rf_ff[ridx];
   end

   // Shifter operand, registered in the second read cycle.
   logic [31:0] sh_val, rot_val;
   logic        sh_c;
   logic [4:0]  rot, samt;
   logic [63:0] rot64;
   logic [32:0] t33;

   always_comb begin
      rot = {ins_ff[11:8], 1'b0};
      samt = ins_ff[11:7];
      sh_val = rval;
      sh_c = flags_ff[1];
      rot64 = '0;
      t33 = '0;
      rot_val = '0;
      if (ins_ff[25]) begin
         rot64 = {24'd0, ins_ff[7:0], 24'd0, ins_ff[7:0]} >> rot;
         rot_val = rot64[31:0];
         sh_val = rot_val;
         if (rot != 5'd0) sh_c = rot_val[31];
      end else begin
         case (ins_ff[6:5])
            aieu_pkg::SHIFT_LSL: begin
               t33 = {1'b0, rval} << samt;
               if (samt != 5'd0) begin
                  sh_val = t33[31:0];
                  sh_c = t33[32];
               end
            end
            aieu_pkg::SHIFT_LSR: begin
               t33 = {rval, 1'b0} >> samt;
               if (samt == 5'd0) begin
                  sh_val = '0;
                  sh_c = rval[31];
               end else begin
                  sh_val = t33[32:1];
                  sh_c = t33[0];
               end
            end
            aieu_pkg::SHIFT_ASR: begin
               t33 = $signed({rval, 1'b0}) >>> samt;
               if (samt == 5'd0) begin
                  sh_val = {32{rval[31]}};
                  sh_c = rval[31];
               end else begin
                  sh_val = t33[32:1];
                  sh_c = t33[0];
               end
            end
            default: begin
               rot64 = {rval, rval} >> samt;
               if (samt == 5'd0) begin
                  sh_val = {flags_ff[1], rval[31:1]};
                  sh_c = rval[0];
               end else begin
                  sh_val = rot64[31:0];
                  sh_c = rot64[31];
               end
            end
         endcase
      end
   end

   // Decode of the held instruction word.
   logic [2:0]  cls;
   logic        is_halt, cond_ok, is_svc, is_b, is_blk, is_sdt, is_bx, is_nop, is_dp;
   logic        fn, fz, fc, fv;

   always_comb begin
      fn = flags_ff[3];
      fz = flags_ff[2];
      fc = flags_ff[1];
      fv = flags_ff[0];
      case (ins_ff[31:28])
         aieu_pkg::COND_EQ: cond_ok = fz;
         aieu_pkg::COND_NE: cond_ok = !fz;
         aieu_pkg::COND_CS: cond_ok = fc;
         aieu_pkg::COND_CC: cond_ok = !fc;
         aieu_pkg::COND_MI: cond_ok = fn;
         aieu_pkg::COND_PL: cond_ok = !fn;
         aieu_pkg::COND_VS: cond_ok = fv;
         aieu_pkg::COND_VC: cond_ok = !fv;
         aieu_pkg::COND_HI: cond_ok = fc && !fz;
         aieu_pkg::COND_LS: cond_ok = !fc || fz;
         aieu_pkg::COND_GE: cond_ok = fn == fv;
         aieu_pkg::COND_LT: cond_ok = fn != fv;
         aieu_pkg::COND_GT: cond_ok = !fz && (fn == fv);
         aieu_pkg::COND_LE: cond_ok = fz || (fn != fv);
         aieu_pkg::COND_AL: cond_ok = 1'b1;
         default:           cond_ok = 1'b0;
      endcase
   end

   assign cls     = ins_ff[27:25];
   assign is_halt = (pc0_ff >= fault_start) && (pc0_ff < fault_end);
   assign is_svc  = ins_ff[27:24] == aieu_pkg::SVC_PATTERN;
   assign is_b    = cls == 3'd5;
   assign is_blk  = cls == 3'd4;
   assign is_sdt  = cls == 3'd2;
   assign is_bx   = (ins_ff & aieu_pkg::BX_MASK) == aieu_pkg::BX_PATTERN;
   assign is_nop  = ins_ff[27:0] == aieu_pkg::NOP_PATTERN;
   assign is_dp   = ((cls == 3'd1) || ((cls == 3'd0) && !ins_ff[4]))
                    && !((ins_ff[24:23] == 2'b10) && !ins_ff[20]);

   // ALU.
   logic [3:0]  op;
   logic [31:0] ax, ay, ar, lr, dr;
   logic        aci, ac, av, arith, dc, dv;
   logic [32:0] sum33;

   assign op = ins_ff[24:21];

   always_comb begin
      arith = 1'b1;
      lr = '0;
      ax = a_ff;
      ay = b_ff;
      aci = 1'b0;
      case (op)
         aieu_pkg::OP_SUB, aieu_pkg::OP_CMP: begin ay = ~b_ff; aci = 1'b1; end
         aieu_pkg::OP_RSB: begin ax = b_ff; ay = ~a_ff; aci = 1'b1; end
         aieu_pkg::OP_ADD, aieu_pkg::OP_CMN: aci = 1'b0;
         aieu_pkg::OP_ADC: aci = flags_ff[1];
         aieu_pkg::OP_SBC: begin ay = ~b_ff; aci = flags_ff[1]; end
         aieu_pkg::OP_RSC: begin ax = b_ff; ay = ~a_ff; aci = flags_ff[1]; end
         aieu_pkg::OP_AND, aieu_pkg::OP_TST: begin lr = a_ff & b_ff; arith = 1'b0; end
         aieu_pkg::OP_EOR, aieu_pkg::OP_TEQ: begin lr = a_ff ^ b_ff; arith = 1'b0; end
         aieu_pkg::OP_ORR: begin lr = a_ff | b_ff; arith = 1'b0; end
         aieu_pkg::OP_MOV: begin lr = b_ff; arith = 1'b0; end
         aieu_pkg::OP_BIC: begin lr = a_ff & ~b_ff; arith = 1'b0; end
         default: begin lr = ~b_ff; arith = 1'b0; end
      endcase
   end

   assign sum33 = {1'b0, ax} + {1'b0, ay} + {32'd0, aci};
   assign ar = sum33[31:0];
   assign ac = sum33[32];
   assign av = (~(ax[31] ^ ay[31])) & (ax[31] ^ ar[31]);
   assign dr = arith ? ar : lr;
   assign dc = arith ? ac : sc_ff;
   assign dv = arith ? av : flags_ff[0];

   // Addresses of single and block transfers.
   logic [31:0] br_off, sdt_off, sdt_sum, sdt_addr, cnt4, blk_start, blk_wbval;
   logic [4:0]  cnt;
   logic [15:0] list;
   logic        sdt_wb, blk_wb;
   logic [3:0]  rn, rd;

   assign rn = ins_ff[19:16];
   assign rd = ins_ff[15:12];
   assign list = ins_ff[15:0];
   assign br_off = {{6{ins_ff[23]}}, ins_ff[23:0], 2'b00};
   assign sdt_off = ins_ff[23] ? {20'd0, ins_ff[11:0]} : 32'd0 - {20'd0, ins_ff[11:0]};
   assign sdt_sum = a_ff + sdt_off;
   assign sdt_addr = ins_ff[24] ? sdt_sum : a_ff;
   assign sdt_wb = (!ins_ff[24] || ins_ff[21]) && (rn != aieu_pkg::PC_INDEX);
   assign cnt = aieu_pkg::pop_count(list);
   assign cnt4 = {25'd0, cnt, 2'b00};
   assign blk_wbval = ins_ff[23] ? a_ff + cnt4 : a_ff - cnt4;
   assign blk_start = ins_ff[23] ? (ins_ff[24] ? a_ff + 32'd4 : a_ff)
                                 : (ins_ff[24] ? blk_wbval : blk_wbval + 32'd4);
   // The base is not written back when it is the highest register an LDM loads.
   assign blk_wb = ins_ff[21] && (rn != aieu_pkg::PC_INDEX)
                   && !(ins_ff[20] && ((list >> rn) == 16'd1));

   // Returned load data.
   logic [3:0]  li;
   logic [31:0] lval;
   logic [15:0] mask_after;

   assign li = aieu_pkg::lowest_set(mask_ff);
   assign lval = pbyte_ff ? {24'd0, ld_ff[7:0]} : ld_ff;
   assign mask_after = mask_ff & ~(16'd1 << li);

   logic ins_path;
   assign ins_path = !cmd_ff && (mask_ff == 16'd0) && !is_halt && cond_ok && !is_svc && !is_b;

   assign sts.to_stm = ins_path && is_blk && (list != 16'd0) && !ins_ff[20];
   assign sts.to_wb = (ins_path && !is_blk && is_sdt && !ins_ff[20])
                      || (cmd_ff && (mask_ff != 16'd0) && (mask_after == 16'd0) && pwbv_ff);
   assign sts.stm_last = (lst_ff & (lst_ff - 16'd1)) == 16'd0;
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   // Next state and result of the firing step.
   always_comb begin
      res = '0;
      res.kind = aieu_pkg::KIND_STEP;
      res.last = 1'b1;
      pc_in = pc_ff;
      flags_in = flags_ff;
      rf_we = 1'b0;
      rf_wi = '0;
      rf_wv = '0;
      mask_in = mask_ff;
      paddr_in = paddr_ff;
      pbyte_in = pbyte_ff;
      pwbv_in = pwbv_ff;
      pwbval_in = pwbval_ff;
      pwbidx_in = pwbidx_ff;
      lst_in = lst_ff;
      saddr_in = saddr_ff;
      emit = 1'b0;
      if (cmd.exec) begin
         emit = !sts.to_stm;
         if (cmd_ff) begin
            if (mask_ff != 16'd0) begin
               mask_in = mask_after;
               if (li == aieu_pkg::PC_INDEX) begin
                  pc_in = lval;
               end else begin
                  rf_we = 1'b1;
                  rf_wi = li;
                  rf_wv = lval;
                  res.rwv = 1'b1;
                  res.rwi = li;
                  res.rwval = lval;
               end
               if (mask_after != 16'd0) begin
                  paddr_in = paddr_ff + 32'd4;
                  res.kind = aieu_pkg::KIND_READ;
                  res.addr = paddr_ff + 32'd4;
                  res.byte_acc = pbyte_ff;
               end else if (pwbv_ff) begin
                  res.last = 1'b0;
               end
            end
         end else if (mask_ff == 16'd0) begin
            if (is_halt) begin
               res.kind = aieu_pkg::KIND_HALT;
            end else if (!cond_ok) begin
               pc_in = pc0_ff + 32'd4;
            end else if (is_svc) begin
               pc_in = pc0_ff + 32'd4;
               res.kind = aieu_pkg::KIND_SVC;
               res.svc = ins_ff[23:0];
            end else if (is_b) begin
               pc_in = pc0_ff + 32'd8 + br_off;
               if (ins_ff[24]) begin
                  rf_we = 1'b1;
                  rf_wi = 4'd14;
                  rf_wv = pc0_ff + 32'd4;
                  res.rwv = 1'b1;
                  res.rwi = 4'd14;
                  res.rwval = pc0_ff + 32'd4;
               end
            end else if (is_blk) begin
               pc_in = pc0_ff + 32'd4;
               if (list != 16'd0) begin
                  pwbv_in = blk_wb;
                  pwbval_in = blk_wbval;
                  pwbidx_in = rn;
                  if (ins_ff[20]) begin
                     mask_in = list;
                     paddr_in = blk_start;
                     pbyte_in = 1'b0;
                     res.kind = aieu_pkg::KIND_READ;
                     res.addr = blk_start;
                  end else begin
                     lst_in = list;
                     saddr_in = blk_start;
                  end
               end
            end else if (is_sdt) begin
               pc_in = pc0_ff + 32'd4;
               pwbv_in = sdt_wb;
               pwbval_in = sdt_sum;
               pwbidx_in = rn;
               res.addr = sdt_addr;
               res.byte_acc = ins_ff[22];
               if (ins_ff[20]) begin
                  mask_in = 16'd1 << rd;
                  paddr_in = sdt_addr;
                  pbyte_in = ins_ff[22];
                  res.kind = aieu_pkg::KIND_READ;
               end else begin
                  res.kind = aieu_pkg::KIND_WRITE;
                  res.wdata = ins_ff[22] ? {24'd0, m_ff[7:0]} : m_ff;
                  res.last = 1'b0;
               end
            end else if (is_bx) begin
               pc_in = {m_ff[31:1], 1'b0};
               if (ins_ff[5]) begin
                  rf_we = 1'b1;
                  rf_wi = 4'd14;
                  rf_wv = pc0_ff + 32'd4;
                  res.rwv = 1'b1;
                  res.rwi = 4'd14;
                  res.rwval = pc0_ff + 32'd4;
               end
            end else if (is_nop || !is_dp) begin
               pc_in = pc0_ff + 32'd4;
            end else begin
               pc_in = pc0_ff + 32'd4;
               if (ins_ff[20]) flags_in = {dr[31], dr == 32'd0, dc, dv};
               case (op)
                  aieu_pkg::OP_TST, aieu_pkg::OP_TEQ, aieu_pkg::OP_CMP,
                  aieu_pkg::OP_CMN: pc_in = pc0_ff + 32'd4;
                  default: begin
                     if (rd == aieu_pkg::PC_INDEX) begin
                        pc_in = dr;
                     end else begin
                        rf_we = 1'b1;
                        rf_wi = rd;
                        rf_wv = dr;
                        res.rwv = 1'b1;
                        res.rwi = rd;
                        res.rwval = dr;
                     end
                  end
               endcase
            end
         end
      end else if (cmd.stm) begin
         emit = 1'b1;
         res.kind = aieu_pkg::KIND_WRITE;
         res.addr = saddr_ff;
         res.wdata = rval;
         res.last = 1'b0;
         saddr_in = saddr_ff + 32'd4;
         lst_in = lst_ff & ~(16'd1 << ridx);
      end else if (cmd.wb) begin
         emit = 1'b1;
         if (pwbv_ff) begin
            rf_we = 1'b1;
            rf_wi = pwbidx_ff;
            rf_wv = pwbval_ff;
            res.rwv = 1'b1;
            res.rwi = pwbidx_ff;
            res.rwval = pwbval_ff;
         end
         pwbv_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 15; k++) rf_ff[k] <= '0;
         pc_ff <= '0;
         flags_ff <= '0;
         mask_ff <= '0;
         paddr_ff <= '0;
         pbyte_ff <= 1'b0;
         pwbv_ff <= 1'b0;
         pwbval_ff <= '0;
         pwbidx_ff <= '0;
         lst_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rf_we && (rf_wi != aieu_pkg::PC_INDEX)) rf_ff[rf_wi] <= rf_wv;
         pc_ff <= pc_in;
         flags_ff <= flags_in;
         mask_ff <= mask_in;
         paddr_ff <= paddr_in;
         pbyte_ff <= pbyte_in;
         pwbv_ff <= pwbv_in;
         pwbval_ff <= pwbval_in;
         pwbidx_ff <= pwbidx_in;
         lst_ff <= lst_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      saddr_ff <= saddr_in;
      if (cmd.accept) begin
         cmd_ff <= req_command;
         ins_ff <= req_instr_word;
         ld_ff <= req_load_data;
         pc0_ff <= pc_ff;
      end
      if (cmd.rd_a) a_ff <= rval;
      if (cmd.rd_b) begin
         m_ff <= rval;
         b_ff <= sh_val;
         sc_ff <= sh_c;
      end
      if (emit) begin
         rsp_ff <= res;
         next_pc_ff <= pc_in;
         nzcv_ff <= flags_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_kind            = rsp_ff.kind;
   assign rsp_mem_address     = rsp_ff.addr;
   assign rsp_write_data      = rsp_ff.wdata;
   assign rsp_byte_access     = rsp_ff.byte_acc;
   assign rsp_next_pc         = next_pc_ff;
   assign rsp_nzcv            = nzcv_ff;
   assign rsp_svc_number      = rsp_ff.svc;
   assign rsp_reg_write_valid = rsp_ff.rwv;
   assign rsp_reg_write_index = rsp_ff.rwi;
   assign rsp_reg_write_value = rsp_ff.rwval;
   assign rsp_last            = rsp_ff.last;

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.accept, cmd.rd_a, cmd.rd_b, cmd.exec, cmd.stm, cmd.wb}))
      else $error("more than one datapath command at once");

   a_stm_list: assert property (@(posedge clock) disable iff (reset)
      cmd.stm |-> (lst_ff != 16'd0))
      else $error("store beat with an empty register list");

   a_wb_index: assert property (@(posedge clock) disable iff (reset)
      pwbv_ff |-> (pwbidx_ff != aieu_pkg::PC_INDEX))
      else $error("writeback pending to the program counter");

   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      emit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result written over a stalled beat");

endmodule

// File: sim/arm_integer_execute_unit_tb.sv
// Self-checking testbench for the ARM integer execute unit: directed table, then random programs.
`timescale 1ns / 1ps
module arm_integer_execute_unit_tb;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] addr;
      logic [31:0] wdata;
      logic        byte_acc;
      logic [31:0] pc;
      logic [3:0]  nzcv;
      logic [23:0] svc;
      logic        rwv;
      logic [3:0]  rwi;
      logic [31:0] rwval;
      logic        last;
   } beat_type;

   typedef struct packed {
      logic        cmd;
      logic [31:0] word;
      logic [31:0] data;
      logic        typed;
      logic [2:0]  kind;
   } dir_row_type;

   localparam int DIR_ROWS = 40;
   localparam dir_row_type DIR_TAB [DIR_ROWS] = '{
      '{1'b1, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, aieu_pkg::KIND_STEP}, // data, none pending
      '{1'b0, 32'hE3A0_04FF, 32'h0, 1'b0, aieu_pkg::KIND_STEP},  // MOV r0, rotated immediate
      '{1'b0, 32'hE3F0_1000, 32'h0, 1'b0, aieu_pkg::KIND_STEP},  // MVNS r1, #0
      '{1'b0, 32'hE291_2001, 32'h0, 1'b0, aieu_pkg::KIND_STEP},  // ADDS r2, r1, #1
      '{1'b0, 32'hE0A1_3001, 32'h0, 1'b0, aieu_pkg::KIND_STEP},  // ADC
      '{1'b0, 32'hE050_4080, 32'h0, 1'b0, aieu_pkg::KIND_STEP},  // SUBS with LSL
      '{1'b0, 32'hE060_7000, 32'h0, 1'b0, aieu_pkg::KIND_STEP},  // RSB
      '{1'b0, 32'hE0C0_6001, 32'h0, 1'b0, aieu_pkg::KIND_STEP},  // SBC
      '{1'b0, 32'hE0E0_5000, 32'h0, 1'b0, aieu_pkg::KIND_STEP},  // RSC
      '{1'b0, 32'hE151_0002, 32'h0, 1'b0, aieu_pkg::KIND_STEP},  // CMP
      '{1'b0, 32'hE171_0001, 32'h0, 1'b0, aieu_pkg::KIND_STEP},  // CMN
      '{1'b0, 32'hE110_0001, 32'h0, 1'b0, aieu_pkg::KIND_STEP},  // TST
      '{1'b0, 32'hE130_0001, 32'h0, 1'b0, aieu_pkg::KIND_STEP},  // TEQ
      '{1'b0, 32'hE001_2000, 32'h0, 1'b0, aieu_pkg::KIND_STEP},  // AND
      '{1'b0, 32'hE021_2000, 32'h0, 1'b0, aieu_pkg::KIND_STEP},  // EOR
      '{1'b0, 32'hE181_2000, 32'h0, 1'b0, aieu_pkg::KIND_STEP},  // ORR
      '{1'b0, 32'hE1C1_3000, 32'h0, 1'b0, aieu_pkg::KIND_STEP},  // BIC
      '{1'b0, 32'hE1B0_4021, 32'h0, 1'b0, aieu_pkg::KIND_STEP},  // LSR by 32
      '{1'b0, 32'hE1B0_4041, 32'h0, 1'b0, aieu_pkg::KIND_STEP},  // ASR by 32
      '{1'b0, 32'hE1B0_4061, 32'h0, 1'b0, aieu_pkg::KIND_STEP},  // RRX
      '{1'b0, 32'hE1A0_4261, 32'h0, 1'b0, aieu_pkg::KIND_STEP},  // ROR by 4
      '{1'b0, 32'hF3A0_0001, 32'h0, 1'b1, aieu_pkg::KIND_STEP},  // condition never passes
      '{1'b0, 32'hEFFF_FFFF, 32'h0, 1'b1, aieu_pkg::KIND_SVC},   // service call, largest number
      '{1'b0, 32'hE520_1004, 32'h0, 1'b0, aieu_pkg::KIND_WRITE}, // STR pre-indexed writeback
      '{1'b0, 32'hE4C0_1001, 32'h0, 1'b0, aieu_pkg::KIND_WRITE}, // STRB post-indexed
      '{1'b0, 32'hE590_2004, 32'h0, 1'b1, aieu_pkg::KIND_READ},  // LDR
      '{1'b0, 32'hE1A0_0000, 32'h0, 1'b1, aieu_pkg::KIND_STEP},  // instruction while load pending
      '{1'b1, 32'h0, 32'h8000_0001, 1'b0, aieu_pkg::KIND_STEP},
      '{1'b0, 32'hE8B0_8006, 32'h0, 1'b1, aieu_pkg::KIND_READ},  // LDMIA with pc in the list
      '{1'b1, 32'h0, 32'h0000_0011, 1'b0, aieu_pkg::KIND_STEP},
      '{1'b1, 32'h0, 32'h0000_0022, 1'b0, aieu_pkg::KIND_STEP},
      '{1'b1, 32'h0, 32'h0000_0100, 1'b0, aieu_pkg::KIND_STEP},
      '{1'b0, 32'hE920_FFFF, 32'h0, 1'b0, aieu_pkg::KIND_STEP},  // STMDB of every register
      '{1'b0, 32'hE890_0000, 32'h0, 1'b1, aieu_pkg::KIND_STEP},  // empty register list
      '{1'b0, 32'hEBFF_FFFE, 32'h0, 1'b0, aieu_pkg::KIND_STEP},  // BL backwards
      '{1'b0, 32'hE12F_FF31, 32'h0, 1'b0, aieu_pkg::KIND_STEP},  // BLX r1
      '{1'b0, 32'hE12F_FF1E, 32'h0, 1'b0, aieu_pkg::KIND_STEP},  // BX lr
      '{1'b0, 32'hE1A0_0000, 32'h0, 1'b1, aieu_pkg::KIND_STEP},  // NOP
      '{1'b0, 32'hE000_0291, 32'h0, 1'b1, aieu_pkg::KIND_STEP},  // multiply is not supported
      '{1'b0, 32'hEA00_0000, 32'h0, 1'b0, aieu_pkg::KIND_STEP}   // B forward
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_command = 1'b0;
   logic [31:0] req_instr_word = 32'h0;
   logic [31:0] req_load_data = 32'h0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_kind;
   logic [31:0] rsp_mem_address;
   logic [31:0] rsp_write_data;
   logic        rsp_byte_access;
   logic [31:0] rsp_next_pc;
   logic [3:0]  rsp_nzcv;
   logic [23:0] rsp_svc_number;
   logic        rsp_reg_write_valid;
   logic [3:0]  rsp_reg_write_index;
   logic [31:0] rsp_reg_write_value;
   logic        rsp_last;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = 3'd0;
   logic [31:0] pwdata = 32'h0;
   logic [31:0] prdata;
   logic        pready;

   arm_integer_execute_unit u_top (.*);

   always #5 clock = ~clock;

   // Predicted architectural state.
   logic [31:0] gpr [16];
   logic [3:0]  flg;
   logic [15:0] ld_mask;
   logic [31:0] ld_addr;
   logic        ld_byte;
   logic        wb_pend;
   logic [31:0] wb_val;
   logic [3:0]  wb_idx;
   logic [31:0] win_lo;
   logic [31:0] win_hi;

   beat_type exp_beats [$];
   int  err_cnt = 0;
   int  items_sent = 0;
   int  beats_seen = 0;
   int  halts_seen = 0;
   bit  calm = 1'b0;
   bit  hold_req = 1'b0;
   int  hold_cnt = 0;

   task automatic emit(input logic [2:0] kind, input logic [31:0] addr, input logic [31:0] wd,
                       input logic byt, input logic [23:0] svc, input logic [3:0] ri,
                       input logic [31:0] rval, input logic rv, input logic last);
      beat_type b;
      logic ok;
      ok = rv && ri != aieu_pkg::PC_INDEX;
      b.kind = kind;  b.addr = addr;  b.wdata = wd;  b.byte_acc = byt;
      b.pc = gpr[15]; b.nzcv = flg;   b.svc = svc;
      b.rwv = ok;     b.rwi = ok ? ri : 4'd0;  b.rwval = ok ? rval : 32'd0;
      b.last = last;
      exp_beats.push_back(b);
   endtask

   task automatic emit_step(input logic [3:0] ri, input logic [31:0] rval, input logic rv,
                            input logic last);
      emit(aieu_pkg::KIND_STEP, '0, '0, 1'b0, '0, ri, rval, rv, last);
   endtask

   function automatic logic [31:0] op_read(input logic [3:0] i, input logic [31:0] pc);
      return i == aieu_pkg::PC_INDEX ? pc + 32'd8 : gpr[i];
   endfunction

   function automatic logic cond_pass(input logic [3:0] c);
      logic n, z, cy, v;
      {n, z, cy, v} = flg;
      case (c)
         aieu_pkg::COND_EQ: return z;
         aieu_pkg::COND_NE: return !z;
         aieu_pkg::COND_CS: return cy;
         aieu_pkg::COND_CC: return !cy;
         aieu_pkg::COND_MI: return n;
         aieu_pkg::COND_PL: return !n;
         aieu_pkg::COND_VS: return v;
         aieu_pkg::COND_VC: return !v;
         aieu_pkg::COND_HI: return cy && !z;
         aieu_pkg::COND_LS: return !cy || z;
         aieu_pkg::COND_GE: return n == v;
         aieu_pkg::COND_LT: return n != v;
         aieu_pkg::COND_GT: return !z && n == v;
         aieu_pkg::COND_LE: return z || n != v;
         aieu_pkg::COND_AL: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic [31:0] operand2(input logic [31:0] ins, input logic [31:0] pc,
                                            output logic co);
      logic [31:0] m, v;
      int s;
      if (ins[25]) begin
         s = 2 * int'(ins[11:8]);
         v = {24'd0, ins[7:0]};
         if (s == 0) begin
            co = flg[1];
            return v;
         end
         v = (v >> s) | (v << (32 - s));
         co = v[31];
         return v;
      end
      m = op_read(ins[3:0], pc);
      s = int'(ins[11:7]);
      case (ins[6:5])
         aieu_pkg::SHIFT_LSL: begin
            if (s == 0) begin
               co = flg[1];
               return m;
            end
            co = m[32 - s];
            return m << s;
         end
         aieu_pkg::SHIFT_LSR: begin
            if (s == 0) begin
               co = m[31];
               return 32'd0;
            end
            co = m[s - 1];
            return m >> s;
         end
         aieu_pkg::SHIFT_ASR: begin
            if (s == 0) begin
               co = m[31];
               return {32{m[31]}};
            end
            co = m[s - 1];
            return $unsigned($signed(m) >>> s);
         end
         default: begin
            if (s == 0) begin
               co = m[0];
               return {flg[1], m[31:1]};
            end
            co = m[s - 1];
            return (m >> s) | (m << (32 - s));
         end
      endcase
   endfunction

   function automatic logic [31:0] add_carry(input logic [31:0] a, input logic [31:0] b,
                                             input logic cin, output logic c, output logic v);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b} + {32'd0, cin};
      c = s[32];
      v = ~(a[31] ^ b[31]) & (a[31] ^ s[31]);
      return s[31:0];
   endfunction

   task automatic store_tail(input logic wb, input logic [3:0] rn, input logic [31:0] val);
      if (wb) begin
         gpr[rn] = val;
         emit_step(rn, val, 1'b1, 1'b1);
      end else begin
         emit_step('0, '0, 1'b0, 1'b1);
      end
   endtask

   task automatic exec_alu(input logic [31:0] ins, input logic [31:0] pc);
      logic [31:0] a, b, r;
      logic sc, c, v, arith;
      logic [3:0] op, rd;
      op = ins[24:21];
      rd = ins[15:12];
      a = op_read(ins[19:16], pc);
      b = operand2(ins, pc, sc);
      c = flg[1];
      v = flg[0];
      arith = 1'b1;
      case (op)
         aieu_pkg::OP_AND, aieu_pkg::OP_TST: begin r = a & b; arith = 1'b0; end
         aieu_pkg::OP_EOR, aieu_pkg::OP_TEQ: begin r = a ^ b; arith = 1'b0; end
         aieu_pkg::OP_SUB, aieu_pkg::OP_CMP: r = add_carry(a, ~b, 1'b1, c, v);
         aieu_pkg::OP_RSB:         r = add_carry(b, ~a, 1'b1, c, v);
         aieu_pkg::OP_ADD, aieu_pkg::OP_CMN: r = add_carry(a, b, 1'b0, c, v);
         aieu_pkg::OP_ADC:         r = add_carry(a, b, flg[1], c, v);
         aieu_pkg::OP_SBC:         r = add_carry(a, ~b, flg[1], c, v);
         aieu_pkg::OP_RSC:         r = add_carry(b, ~a, flg[1], c, v);
         aieu_pkg::OP_ORR:         begin r = a | b; arith = 1'b0; end
         aieu_pkg::OP_MOV:         begin r = b; arith = 1'b0; end
         aieu_pkg::OP_BIC:         begin r = a & ~b; arith = 1'b0; end
         default:                  begin r = ~b; arith = 1'b0; end
      endcase
      if (!arith) c = sc;
      if (ins[20]) flg = {r[31], r == 32'd0, c, v};
      gpr[15] = pc + 32'd4;
      if (op inside {aieu_pkg::OP_TST, aieu_pkg::OP_TEQ, aieu_pkg::OP_CMP,
                     aieu_pkg::OP_CMN}) begin
         emit_step('0, '0, 1'b0, 1'b1);
      end else if (rd == aieu_pkg::PC_INDEX) begin
         gpr[15] = r;
         emit_step('0, '0, 1'b0, 1'b1);
      end else begin
         gpr[rd] = r;
         emit_step(rd, r, 1'b1, 1'b1);
      end
   endtask

   task automatic exec_single(input logic [31:0] ins, input logic [31:0] pc);
      logic [3:0] rn, rd;
      logic [31:0] base, off, addr, wbv, val;
      logic wb;
      rn = ins[19:16];
      rd = ins[15:12];
      base = op_read(rn, pc);
      off = ins[23] ? {20'd0, ins[11:0]} : 32'd0 - {20'd0, ins[11:0]};
      addr = ins[24] ? base + off : base;
      wbv = base + off;
      wb = (!ins[24] || ins[21]) && rn != aieu_pkg::PC_INDEX;
      if (ins[20]) begin
         gpr[15] = pc + 32'd4;
         ld_mask = 16'd1 << rd;
         ld_addr = addr;
         ld_byte = ins[22];
         wb_pend = wb;
         wb_val = wbv;
         wb_idx = rn;
         emit(aieu_pkg::KIND_READ, addr, '0, ins[22], '0, '0, '0, 1'b0, 1'b1);
      end else begin
         val = op_read(rd, pc);
         if (ins[22]) val = val & 32'hFF;
         gpr[15] = pc + 32'd4;
         emit(aieu_pkg::KIND_WRITE, addr, val, ins[22], '0, '0, '0, 1'b0, 1'b0);
         store_tail(wb, rn, wbv);
      end
   endtask

   task automatic exec_block(input logic [31:0] ins, input logic [31:0] pc);
      logic [3:0] rn, hi;
      logic [15:0] list;
      logic [31:0] base, start, wbv, cnt4;
      logic [31:0] vals [16];
      logic wb;
      int cnt;
      rn = ins[19:16];
      list = ins[15:0];
      base = op_read(rn, pc);
      cnt = 0;
      hi = 4'd0;
      if (list == 16'd0) begin
         gpr[15] = pc + 32'd4;
         emit_step('0, '0, 1'b0, 1'b1);
      end else begin
         for (int i = 0; i < 16; i++) if (list[i]) begin cnt++; hi = 4'(i); end
         cnt4 = 32'(4 * cnt);
         if (ins[23]) begin
            start = ins[24] ? base + 32'd4 : base;
            wbv = base + cnt4;
         end else begin
            start = ins[24] ? base - cnt4 : base - cnt4 + 32'd4;
            wbv = base - cnt4;
         end
         wb = ins[21] && rn != aieu_pkg::PC_INDEX && !(ins[20] && list[rn] && hi == rn);
         if (ins[20]) begin
            gpr[15] = pc + 32'd4;
            ld_mask = list;
            ld_addr = start;
            ld_byte = 1'b0;
            wb_pend = wb;
            wb_val = wbv;
            wb_idx = rn;
            emit(aieu_pkg::KIND_READ, start, '0, 1'b0, '0, '0, '0, 1'b0, 1'b1);
         end else begin
            for (int i = 0; i < 16; i++) vals[i] = op_read(4'(i), pc);
            gpr[15] = pc + 32'd4;
            for (int i = 0; i < 16; i++) begin
               if (list[i]) begin
                  emit(aieu_pkg::KIND_WRITE, start, vals[i], 1'b0, '0, '0, '0, 1'b0, 1'b0);
                  start = start + 32'd4;
               end
            end
            store_tail(wb, rn, wbv);
         end
      end
   endtask

   task automatic load_answer(input logic [31:0] data);
      logic [3:0] idx;
      logic [31:0] val;
      val = ld_byte ? {24'd0, data[7:0]} : data;
      idx = aieu_pkg::PC_INDEX;
      for (int i = 14; i >= 0; i--) if (ld_mask[i]) idx = 4'(i);
      gpr[idx] = val;
      ld_mask[idx] = 1'b0;
      if (ld_mask != 16'd0) begin
         ld_addr = ld_addr + 32'd4;
         emit(aieu_pkg::KIND_READ, ld_addr, '0, ld_byte, '0, idx, val, 1'b1, 1'b1);
      end else if (!wb_pend) begin
         emit_step(idx, val, 1'b1, 1'b1);
      end else begin
         emit_step(idx, val, 1'b1, 1'b0);
         gpr[wb_idx] = wb_val;
         wb_pend = 1'b0;
         emit_step(wb_idx, gpr[wb_idx], 1'b1, 1'b1);
      end
   endtask

   // Works out every result beat caused by one accepted request beat.
   task automatic execute_item(input logic cmd, input logic [31:0] ins, input logic [31:0] data);
      logic [31:0] pc, off, target;
      pc = gpr[15];
      if (cmd) begin
         if (ld_mask == 16'd0) emit_step('0, '0, 1'b0, 1'b1);
         else load_answer(data);
      end else if (ld_mask != 16'd0) begin
         emit_step('0, '0, 1'b0, 1'b1);
      end else if (pc >= win_lo && pc < win_hi) begin
         emit(aieu_pkg::KIND_HALT, '0, '0, 1'b0, '0, '0, '0, 1'b0, 1'b1);
      end else if (!cond_pass(ins[31:28])) begin
         gpr[15] = pc + 32'd4;
         emit_step('0, '0, 1'b0, 1'b1);
      end else if (ins[27:24] == aieu_pkg::SVC_PATTERN) begin
         gpr[15] = pc + 32'd4;
         emit(aieu_pkg::KIND_SVC, '0, '0, 1'b0, ins[23:0], '0, '0, 1'b0, 1'b1);
      end else if (ins[27:25] == 3'b101) begin
         off = {{6{ins[23]}}, ins[23:0], 2'b00};
         gpr[15] = pc + 32'd8 + off;
         if (ins[24]) begin
            gpr[14] = pc + 32'd4;
            emit_step(4'd14, pc + 32'd4, 1'b1, 1'b1);
         end else begin
            emit_step('0, '0, 1'b0, 1'b1);
         end
      end else if (ins[27:25] == 3'b100) begin
         exec_block(ins, pc);
      end else if (ins[27:25] == 3'b010) begin
         exec_single(ins, pc);
      end else if ((ins & aieu_pkg::BX_MASK) == aieu_pkg::BX_PATTERN) begin
         target = op_read(ins[3:0], pc) & ~32'd1;
         gpr[15] = target;
         if (ins[5]) begin
            gpr[14] = pc + 32'd4;
            emit_step(4'd14, pc + 32'd4, 1'b1, 1'b1);
         end else begin
            emit_step('0, '0, 1'b0, 1'b1);
         end
      end else if (ins[27:0] == aieu_pkg::NOP_PATTERN) begin
         gpr[15] = pc + 32'd4;
         emit_step('0, '0, 1'b0, 1'b1);
      end else if ((ins[27:25] == 3'b001 || (ins[27:25] == 3'b000 && !ins[4])) &&
                   !(ins[24:23] == 2'b10 && !ins[20])) begin
         exec_alu(ins, pc);
      end else begin
         gpr[15] = pc + 32'd4;
         emit_step('0, '0, 1'b0, 1'b1);
      end
   endtask

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   // Drives one request beat and waits for it to be taken.
   task automatic send_beat(input logic cmd, input logic [31:0] word, input logic [31:0] data);
      int g;
      g = gap_len();
      @(negedge clock);
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_instr_word <= word;
      req_load_data <= data;
      do @(posedge clock); while (req_stall);
      execute_item(cmd, word, data);
      items_sent++;
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic csr_check(input logic [2:0] addr, input logic [31:0] want);
      @(negedge clock);
      paddr <= addr;
      @(posedge clock);
      if (prdata !== want) begin
         $display("%0t: register read mismatch, expected %h, actual %h", $realtime, want,
                  prdata);
         err_cnt++;
      end
   endtask

   // Waits for the block to drain, then moves the fault window.
   task automatic set_window(input logic [31:0] lo, input logic [31:0] hi);
      @(negedge clock);
      req_valid <= 1'b0;
      wait (exp_beats.size() == 0);
      repeat (12) @(negedge clock);
      csr_write({aieu_pkg::REG_FAULT_START, 2'b00}, lo);
      csr_write({aieu_pkg::REG_FAULT_END, 2'b00}, hi);
      csr_check({aieu_pkg::REG_FAULT_START, 2'b00}, lo);
      csr_check({aieu_pkg::REG_FAULT_END, 2'b00}, hi);
      win_lo = lo;
      win_hi = hi;
   endtask

   function automatic logic [31:0] random_word();
      logic [3:0] cond;
      logic [23:0] boff;
      cond = ($urandom_range(0, 9) < 8) ? aieu_pkg::COND_AL : 4'($urandom_range(0, 15));
      boff = 24'($signed($urandom_range(0, 64)) - 32);
      case ($urandom_range(0, 11))
         0, 1, 2: return ($urandom_range(0, 1) == 1)
                  ? {cond, 3'b001, 25'($urandom)}
                  : {cond, 3'b000, 5'($urandom), 4'($urandom), 4'($urandom), 7'($urandom),
                     1'b0, 4'($urandom)};
         3, 4:    return {cond, 3'b010, 5'($urandom), 4'($urandom_range(0, 14)),
                          4'($urandom), 12'($urandom)};
         5, 6:    return {cond, 3'b100, 2'($urandom), 1'b0, 2'($urandom), 4'($urandom),
                          16'($urandom & $urandom)};
         7:       return {cond, 3'b101, 1'($urandom), boff};
         8:       return {cond, 20'h12FFF, 2'b00, 1'($urandom), 1'b1, 4'($urandom)};
         9:       return {cond, aieu_pkg::SVC_PATTERN, 24'($urandom)};
         10:      return {cond, aieu_pkg::NOP_PATTERN};
         default: return $urandom;
      endcase
   endfunction

   task automatic random_run(input int n);
      logic cmd;
      for (int k = 0; k < n; k++) begin
         if (ld_mask != 16'd0) cmd = ($urandom_range(0, 99) < 88);
         else cmd = ($urandom_range(0, 99) < 5);
         send_beat(cmd, random_word(), $urandom);
      end
   endtask

   // Receiver: random stalls, a few longer hold-offs, plus a long one when asked for.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            hold_cnt = 80;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_stall <= 1'b1;
         end else if (!calm && $urandom_range(0, 99) < 2) begin
            hold_cnt = $urandom_range(10, 30);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(0, 99) < 25);
         end
      end
   end

   always @(posedge clock) begin
      beat_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_kind, rsp_mem_address, rsp_write_data, rsp_byte_access, rsp_next_pc,
                 rsp_nzcv, rsp_svc_number, rsp_reg_write_valid, rsp_reg_write_index,
                 rsp_reg_write_value, rsp_last};
         beats_seen++;
         if (rsp_kind == aieu_pkg::KIND_HALT) halts_seen++;
         if (exp_beats.size() == 0) begin
            $display("%0t: result beat with nothing expected: %p", $realtime, got);
            err_cnt++;
         end else begin
            want = exp_beats.pop_front();
            if (got !== want) begin
               $display("%0t: mismatch, expected %p", $realtime, want);
               $display("%0t:           actual   %p", $realtime, got);
               err_cnt++;
            end
         end
      end
   end

   initial begin
      #20_000_000;
      $display("** arm_integer_execute_unit: FAILED **");
      $finish;
   end

   initial begin
      for (int i = 0; i < 16; i++) gpr[i] = 32'd0;
      flg = 4'd0;
      ld_mask = 16'd0;
      ld_addr = 32'd0;
      ld_byte = 1'b0;
      wb_pend = 1'b0;
      wb_val = 32'd0;
      wb_idx = 4'd0;
      win_lo = aieu_pkg::FAULT_START_RST;
      win_hi = aieu_pkg::FAULT_END_RST;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      calm = 1'b1;
      for (int r = 0; r < DIR_ROWS; r++) begin
         send_beat(DIR_TAB[r].cmd, DIR_TAB[r].word, DIR_TAB[r].data);
         if (DIR_TAB[r].typed) exp_beats[exp_beats.size() - 1].kind = DIR_TAB[r].kind;
      end
      calm = 1'b0;

      set_window(32'd0, 32'hFFFF_FFFF);
      random_run(5);
      set_window(32'd0, 32'd0);
      random_run(20);
      set_window(32'hFFFF_FFF0, 32'hFFFF_FFFF);
      hold_req = 1'b1;
      random_run(25);
      set_window(aieu_pkg::FAULT_START_RST, aieu_pkg::FAULT_END_RST);
      calm = 1'b1;
      random_run(15);
      calm = 1'b0;
      set_window(32'h0000_1000, 32'h0000_2000);
      random_run(25);

      @(negedge clock);
      req_valid <= 1'b0;
      wait (exp_beats.size() == 0);
      repeat (20) @(posedge clock);
      $display("Sent %0d request beats and checked %0d result beats (%0d halts).",
               items_sent, beats_seen, halts_seen);
      $display("Fault window moved through empty, full and top-of-memory settings.");
      if (err_cnt == 0 && exp_beats.size() == 0) begin
         $display("** arm_integer_execute_unit: PASSED **");
      end else begin
         $display("** arm_integer_execute_unit: FAILED **");
      end
      $finish;
   end

endmodule

// File: filelist.f
hdl/aieu_pkg.sv
hdl/aieu_ctrl.sv
hdl/aieu_dpath.sv
hdl/arm_integer_execute_unit.sv
sim/arm_integer_execute_unit_tb.sv
